### rtl/core/rpcm_pkg.sv
// shared constants, types and helper functions for the ray pair closest midpoint block
// no dependencies; imported by ray_pair_closest_midpoint_top
`default_nettype none

package rpcm_pkg;

  localparam int FracBits  = 16;
  localparam int InW       = 32;
  localparam int DifW      = InW + 1;
  localparam int AccW      = 67;
  localparam int LoW       = 32;
  localparam int HiW       = AccW - LoW;
  localparam int WideW     = 136;
  localparam int NumW      = WideW + FracBits + 2;
  localparam int DenW      = WideW;
  localparam int QW        = InW;
  localparam int MidW      = 68;
  localparam int RootW     = 32;
  localparam int RemW      = RootW + 3;
  localparam int RadW      = 2 * RootW;
  localparam int DivSteps  = QW;
  localparam int SqrtSteps = RootW;
  localparam int PreStages = 9;
  localparam int PipeDepth = PreStages + DivSteps + 1 + 5 + SqrtSteps + 1 + 1;

  localparam logic [InW-1:0] MaxWord = {1'b0, {(InW-1){1'b1}}};
  localparam logic [InW-1:0] MinWord = {1'b1, {(InW-1){1'b0}}};

  typedef struct packed {
    logic [2:0][InW-1:0] v1;
    logic [2:0][InW-1:0] q1;
    logic [2:0][InW-1:0] v2;
    logic [2:0][InW-1:0] q2;
    logic                par;
  } geo_t;

  typedef struct packed {
    logic signed [2*HiW-1:0]  hh;
    logic signed [HiW+LoW:0]  hl;
    logic signed [HiW+LoW:0]  lh;
    logic        [2*LoW-1:0]  ll;
  } pp_t;

  typedef struct packed {
    geo_t            g;
    logic [DenW-1:0] r1;
    logic [DenW-1:0] r2;
    logic [DenW-1:0] d;
    logic [QW-1:0]   ul1;
    logic [QW-1:0]   ul2;
    logic [QW-1:0]   qt1;
    logic [QW-1:0]   qt2;
    logic            neg1;
    logic            neg2;
    logic            ovf1;
    logic            ovf2;
  } dv_t;

  typedef struct packed {
    logic [2:0][InW-1:0] mid;
    logic [InW-1:0]      lam1;
    logic [InW-1:0]      lam2;
    logic                par;
    logic                big;
    logic [RemW-1:0]     rem;
    logic [RootW-1:0]    root;
    logic [RadW-1:0]     xs;
  } sq_t;

  function automatic pp_t pp_split(input logic signed [AccW-1:0] x,
                                   input logic signed [AccW-1:0] y);
    pp_t p;
    logic signed [HiW-1:0] xh;
    logic signed [HiW-1:0] yh;
    logic signed [LoW:0]   xl;
    logic signed [LoW:0]   yl;
    xh = x[AccW-1:LoW];
    yh = y[AccW-1:LoW];
    xl = {1'b0, x[LoW-1:0]};
    yl = {1'b0, y[LoW-1:0]};
    p.hh = xh * yh;
    p.hl = xh * yl;
    p.lh = xl * yh;
    p.ll = x[LoW-1:0] * y[LoW-1:0];
    return p;
  endfunction

  function automatic logic signed [WideW-1:0] pp_join(input pp_t p);
    logic signed [WideW-1:0] hh;
    logic signed [WideW-1:0] hl;
    logic signed [WideW-1:0] lh;
    logic signed [WideW-1:0] ll;
    hh = WideW'($signed(p.hh));
    hl = WideW'($signed(p.hl));
    lh = WideW'($signed(p.lh));
    ll = WideW'(p.ll);
    return (hh <<< (2 * LoW)) + ((hl + lh) <<< LoW) + ll;
  endfunction

  function automatic logic [InW-1:0] sat_word(input logic signed [MidW-1:0] v);
    logic [InW-1:0] r;
    if (!v[MidW-1] && (|v[MidW-2:InW-1])) begin
      r = MaxWord;
    end else if (v[MidW-1] && !(&v[MidW-2:InW-1])) begin
      r = MinWord;
    end else begin
      r = v[InW-1:0];
    end
    return r;
  endfunction

  function automatic logic [InW-1:0] lam_sat(input logic [QW-1:0] q, input logic neg,
                                             input logic ovf);
    logic [InW-1:0] r;
    if (!neg) begin
      r = (ovf || q[QW-1]) ? MaxWord : q;
    end else begin
      r = (ovf || (q[QW-1] && (|q[QW-2:0]))) ? MinWord : (-q);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ray_pair_closest_midpoint_top.sv
// closest approach of two 3d rays: midpoint, ray parameters and gap, fully pipelined
// depends on rpcm_pkg
`default_nettype none

// Usage:
// - input channel in_valid_i / in_ready_o carries one ray pair per item: direction and
//   origin of each ray, signed fixed point with FracBits fraction bits
// - output channel out_valid_o / out_ready_i carries the midpoint of the closest points,
//   both ray parameters, the gap between the closest points and the parallel flag
// - an item is taken on every cycle in which the pipeline can advance, so the sustained
//   rate is one item per cycle while the receiver keeps out_ready_i high
// - the pipeline is PipeDepth stages deep: nine stages of dot products,
//   wide products and numerator set-up, a long divider retiring one quotient bit per stage
//   for each ray parameter, five stages of midpoint and squared gap, an integer square root
//   retiring one root bit per stage, and the output register
// - the whole pipeline advances together; while a result waits at the output and the
//   receiver holds out_ready_i low, every stage holds and in_ready_o is low, nothing is
//   lost or repeated
// - reset clears all valid bits, the block is ready straight after reset
// - when the rays are parallel or a direction is zero, parallel_o is set and the other
//   result fields are zero; all other results saturate at the field limits
module ray_pair_closest_midpoint_top import rpcm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [InW-1:0] dir_one_x_i,
  input  logic signed [InW-1:0] dir_one_y_i,
  input  logic signed [InW-1:0] dir_one_z_i,
  input  logic signed [InW-1:0] org_one_x_i,
  input  logic signed [InW-1:0] org_one_y_i,
  input  logic signed [InW-1:0] org_one_z_i,
  input  logic signed [InW-1:0] dir_two_x_i,
  input  logic signed [InW-1:0] dir_two_y_i,
  input  logic signed [InW-1:0] dir_two_z_i,
  input  logic signed [InW-1:0] org_two_x_i,
  input  logic signed [InW-1:0] org_two_y_i,
  input  logic signed [InW-1:0] org_two_z_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [InW-1:0] mid_x_o,
  output logic signed [InW-1:0] mid_y_o,
  output logic signed [InW-1:0] mid_z_o,
  output logic        [InW-1:0] gap_o,
  output logic signed [InW-1:0] lambda_one_o,
  output logic signed [InW-1:0] lambda_two_o,
  output logic                  parallel_o
);

  localparam int DivLastStg = PreStages + DivSteps;

  logic                 adv;
  logic [PipeDepth-1:0] vld_q;

  assign adv        = !vld_q[PipeDepth-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PipeDepth-2:0], in_valid_i};
    end
  end

  // front end: differences, dot products, normal equation terms
  geo_t                    s0_q, s1_geo_q, s2_geo_q, s3_geo_q, s4_geo_q, s5_geo_q;
  geo_t                    s6_geo_d, s6_geo_q, s7_geo_q, s8_geo_q;
  logic signed [DifW-1:0]  s1_d_d [3];
  logic signed [DifW-1:0]  s1_d_q [3];
  logic signed [2*InW-1:0] s2_aa_d [3], s2_ab_d [3], s2_bb_d [3];
  logic signed [2*InW-1:0] s2_aa_q [3], s2_ab_q [3], s2_bb_q [3];
  logic signed [InW+DifW-1:0] s2_ae_d [3], s2_bg_d [3];
  logic signed [InW+DifW-1:0] s2_ae_q [3], s2_bg_q [3];
  logic signed [AccW-1:0]  s3_a_d, s3_b_d, s3_c_d, s3_e_d, s3_g_d;
  logic signed [AccW-1:0]  s3_a_q, s3_b_q, s3_c_q, s3_e_q, s3_g_q;
  pp_t                     s4_ac_q, s4_bb_q, s4_ce_q, s4_bg_q, s4_be_q, s4_ag_q;
  logic signed [WideW-1:0] s5_ac_q, s5_bb_q, s5_ce_q, s5_bg_q, s5_be_q, s5_ag_q;
  logic signed [WideW-1:0] s6_det_d, s6_det_q, s6_n1_q, s6_n2_q;
  logic signed [NumW-1:0]  s7_n1_q, s7_n2_q;
  logic        [DenW-1:0]  s7_den_q, s8_den_q;
  logic        [NumW-1:0]  s8_u1_d, s8_u2_d, s8_u1_q, s8_u2_q;
  logic                    s8_neg1_q, s8_neg2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_d_d[i]  = DifW'($signed(s0_q.q2[i])) - DifW'($signed(s0_q.q1[i]));
      s2_aa_d[i] = $signed(s1_geo_q.v1[i]) * $signed(s1_geo_q.v1[i]);
      s2_ab_d[i] = $signed(s1_geo_q.v1[i]) * $signed(s1_geo_q.v2[i]);
      s2_bb_d[i] = $signed(s1_geo_q.v2[i]) * $signed(s1_geo_q.v2[i]);
      s2_ae_d[i] = $signed(s1_geo_q.v1[i]) * s1_d_q[i];
      s2_bg_d[i] = $signed(s1_geo_q.v2[i]) * s1_d_q[i];
    end
    s3_a_d = AccW'(s2_aa_q[0]) + AccW'(s2_aa_q[1]) + AccW'(s2_aa_q[2]);
    s3_b_d = AccW'(s2_ab_q[0]) + AccW'(s2_ab_q[1]) + AccW'(s2_ab_q[2]);
    s3_c_d = AccW'(s2_bb_q[0]) + AccW'(s2_bb_q[1]) + AccW'(s2_bb_q[2]);
    s3_e_d = AccW'(s2_ae_q[0]) + AccW'(s2_ae_q[1]) + AccW'(s2_ae_q[2]);
    s3_g_d = -(AccW'(s2_bg_q[0]) + AccW'(s2_bg_q[1]) + AccW'(s2_bg_q[2]));
    s6_det_d     = s5_ac_q - s5_bb_q;
    s6_geo_d     = s5_geo_q;
    s6_geo_d.par = s6_det_d[WideW-1] || (s6_det_d == '0);
    s8_u1_d = s7_n1_q[NumW-1] ? (NumW'(-s7_n1_q) + NumW'(s7_den_q) - NumW'(1))
                              : NumW'(s7_n1_q);
    s8_u2_d = s7_n2_q[NumW-1] ? (NumW'(-s7_n2_q) + NumW'(s7_den_q) - NumW'(1))
                              : NumW'(s7_n2_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q.v1  <= {dir_one_z_i, dir_one_y_i, dir_one_x_i};
      s0_q.q1  <= {org_one_z_i, org_one_y_i, org_one_x_i};
      s0_q.v2  <= {dir_two_z_i, dir_two_y_i, dir_two_x_i};
      s0_q.q2  <= {org_two_z_i, org_two_y_i, org_two_x_i};
      s0_q.par <= 1'b0;
      s1_geo_q <= s0_q;
      s1_d_q   <= s1_d_d;
      s2_geo_q <= s1_geo_q;
      s2_aa_q  <= s2_aa_d;
      s2_ab_q  <= s2_ab_d;
      s2_bb_q  <= s2_bb_d;
      s2_ae_q  <= s2_ae_d;
      s2_bg_q  <= s2_bg_d;
      s3_geo_q <= s2_geo_q;
      s3_a_q   <= s3_a_d;
      s3_b_q   <= s3_b_d;
      s3_c_q   <= s3_c_d;
      s3_e_q   <= s3_e_d;
      s3_g_q   <= s3_g_d;
      s4_geo_q <= s3_geo_q;
      s4_ac_q  <= pp_split(s3_a_q, s3_c_q);
      s4_bb_q  <= pp_split(s3_b_q, s3_b_q);
      s4_ce_q  <= pp_split(s3_c_q, s3_e_q);
      s4_bg_q  <= pp_split(s3_b_q, s3_g_q);
      s4_be_q  <= pp_split(s3_b_q, s3_e_q);
      s4_ag_q  <= pp_split(s3_a_q, s3_g_q);
      s5_geo_q <= s4_geo_q;
      s5_ac_q  <= pp_join(s4_ac_q);
      s5_bb_q  <= pp_join(s4_bb_q);
      s5_ce_q  <= pp_join(s4_ce_q);
      s5_bg_q  <= pp_join(s4_bg_q);
      s5_be_q  <= pp_join(s4_be_q);
      s5_ag_q  <= pp_join(s4_ag_q);
      s6_geo_q <= s6_geo_d;
      s6_det_q <= s6_det_d;
      s6_n1_q  <= s5_ce_q + s5_bg_q;
      s6_n2_q  <= s5_be_q + s5_ag_q;
      s7_geo_q <= s6_geo_q;
      s7_n1_q  <= (NumW'(s6_n1_q) <<< (FracBits + 1)) + NumW'(s6_det_q);
      s7_n2_q  <= (NumW'(s6_n2_q) <<< (FracBits + 1)) + NumW'(s6_det_q);
      s7_den_q <= {s6_det_q[DenW-2:0], 1'b0};
      s8_geo_q <= s7_geo_q;
      s8_den_q <= s7_den_q;
      s8_u1_q  <= s8_u1_d;
      s8_u2_q  <= s8_u2_d;
      s8_neg1_q <= s7_n1_q[NumW-1];
      s8_neg2_q <= s7_n2_q[NumW-1];
    end
  end

  // long division, one quotient bit per stage for each ray parameter
  dv_t dv_d [DivSteps+1];
  dv_t dv_q [DivSteps+1];

  always_comb begin
    logic [DenW:0] r2a;
    logic [DenW:0] r2b;
    logic [DenW:0] dx;
    logic          gea;
    logic          geb;
    dv_d[0].g    = s8_geo_q;
    dv_d[0].d    = s8_den_q;
    dv_d[0].r1   = DenW'(s8_u1_q >> QW);
    dv_d[0].r2   = DenW'(s8_u2_q >> QW);
    dv_d[0].ul1  = s8_u1_q[QW-1:0];
    dv_d[0].ul2  = s8_u2_q[QW-1:0];
    dv_d[0].qt1  = '0;
    dv_d[0].qt2  = '0;
    dv_d[0].neg1 = s8_neg1_q;
    dv_d[0].neg2 = s8_neg2_q;
    dv_d[0].ovf1 = (s8_u1_q >> QW) >= NumW'(s8_den_q);
    dv_d[0].ovf2 = (s8_u2_q >> QW) >= NumW'(s8_den_q);
    for (int k = 0; k < DivSteps; k++) begin
      dx  = {1'b0, dv_q[k].d};
      r2a = {dv_q[k].r1, dv_q[k].ul1[QW-1]};
      r2b = {dv_q[k].r2, dv_q[k].ul2[QW-1]};
      gea = r2a >= dx;
      geb = r2b >= dx;
      dv_d[k+1]     = dv_q[k];
      dv_d[k+1].r1  = gea ? DenW'(r2a - dx) : DenW'(r2a);
      dv_d[k+1].r2  = geb ? DenW'(r2b - dx) : DenW'(r2b);
      dv_d[k+1].ul1 = {dv_q[k].ul1[QW-2:0], 1'b0};
      dv_d[k+1].ul2 = {dv_q[k].ul2[QW-2:0], 1'b0};
      dv_d[k+1].qt1 = {dv_q[k].qt1[QW-2:0], gea};
      dv_d[k+1].qt2 = {dv_q[k].qt2[QW-2:0], geb};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q <= dv_d;
    end
  end

  // back end: lambdas, closest points, midpoint and squared gap
  geo_t                    sl_geo_q, sp_geo_q;
  logic [InW-1:0]          sl_lam1_q, sl_lam2_q, sp_lam1_q, sp_lam2_q;
  logic [InW-1:0]          sm_lam1_q, sm_lam2_q, sx_lam1_q, sx_lam2_q;
  logic [InW-1:0]          sy_lam1_q, sy_lam2_q;
  logic                    sm_par_q, sx_par_q, sy_par_q;
  logic signed [2*InW-1:0] sp_p1_d [3], sp_p2_d [3];
  logic signed [2*InW-1:0] sp_p1_q [3], sp_p2_q [3];
  logic signed [MidW-1:0]  sm_m_d [3], sm_m_q [3];
  logic signed [AccW-1:0]  sm_dd_d [3], sm_dd_q [3];
  logic [2:0][InW-1:0]     sx_mid_q, sy_mid_q;
  pp_t                     sx_pp_q [3];
  logic signed [WideW-1:0] sy_sq_q [3];
  logic [WideW-1:0]        sz_sum, sz_t;
  sq_t                     sq_d [SqrtSteps+1];
  sq_t                     sq_q [SqrtSteps+1];

  always_comb begin
    logic signed [DifW-1:0] qs;
    logic signed [DifW-1:0] qd;
    for (int i = 0; i < 3; i++) begin
      sp_p1_d[i] = $signed(sl_lam1_q) * $signed(sl_geo_q.v1[i]);
      sp_p2_d[i] = $signed(sl_lam2_q) * $signed(sl_geo_q.v2[i]);
      qs = DifW'($signed(sp_geo_q.q1[i])) + DifW'($signed(sp_geo_q.q2[i]));
      qd = DifW'($signed(sp_geo_q.q2[i])) - DifW'($signed(sp_geo_q.q1[i]));
      sm_m_d[i]  = MidW'(sp_p1_q[i]) + MidW'(sp_p2_q[i]) + (MidW'(qs) <<< FracBits)
                 + (MidW'(1) <<< FracBits);
      sm_dd_d[i] = AccW'(sp_p2_q[i]) - AccW'(sp_p1_q[i]) + (AccW'(qd) <<< FracBits);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sl_geo_q  <= dv_q[DivSteps].g;
      sl_lam1_q <= dv_q[DivSteps].g.par ? '0
                   : lam_sat(dv_q[DivSteps].qt1, dv_q[DivSteps].neg1, dv_q[DivSteps].ovf1);
      sl_lam2_q <= dv_q[DivSteps].g.par ? '0
                   : lam_sat(dv_q[DivSteps].qt2, dv_q[DivSteps].neg2, dv_q[DivSteps].ovf2);
      sp_geo_q  <= sl_geo_q;
      sp_lam1_q <= sl_lam1_q;
      sp_lam2_q <= sl_lam2_q;
      sp_p1_q   <= sp_p1_d;
      sp_p2_q   <= sp_p2_d;
      sm_par_q  <= sp_geo_q.par;
      sm_lam1_q <= sp_lam1_q;
      sm_lam2_q <= sp_lam2_q;
      sm_m_q    <= sm_m_d;
      sm_dd_q   <= sm_dd_d;
      sx_par_q  <= sm_par_q;
      sx_lam1_q <= sm_lam1_q;
      sx_lam2_q <= sm_lam2_q;
      for (int i = 0; i < 3; i++) begin
        sx_mid_q[i] <= sat_word(sm_m_q[i] >>> (FracBits + 1));
        sx_pp_q[i]  <= pp_split(sm_dd_q[i], sm_dd_q[i]);
        sy_sq_q[i]  <= pp_join(sx_pp_q[i]);
      end
      sy_par_q  <= sx_par_q;
      sy_lam1_q <= sx_lam1_q;
      sy_lam2_q <= sx_lam2_q;
      sy_mid_q  <= sx_mid_q;
    end
  end

  // integer square root, one root bit per stage
  always_comb begin
    logic [RemW-1:0] rem2;
    logic [RemW-1:0] trial;
    logic            ge;
    sz_sum = WideW'(sy_sq_q[0] + sy_sq_q[1] + sy_sq_q[2]);
    sz_t   = sz_sum >> (2 * FracBits);
    sq_d[0].mid  = sy_mid_q;
    sq_d[0].lam1 = sy_lam1_q;
    sq_d[0].lam2 = sy_lam2_q;
    sq_d[0].par  = sy_par_q;
    sq_d[0].big  = |sz_t[WideW-1:RadW];
    sq_d[0].rem  = '0;
    sq_d[0].root = '0;
    sq_d[0].xs   = sz_t[RadW-1:0];
    for (int k = 0; k < SqrtSteps; k++) begin
      rem2  = {sq_q[k].rem[RemW-3:0], sq_q[k].xs[RadW-1:RadW-2]};
      trial = {1'b0, sq_q[k].root, 2'b01};
      ge    = rem2 >= trial;
      sq_d[k+1]      = sq_q[k];
      sq_d[k+1].rem  = ge ? (rem2 - trial) : rem2;
      sq_d[k+1].root = {sq_q[k].root[RootW-2:0], ge};
      sq_d[k+1].xs   = {sq_q[k].xs[RadW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q <= sq_d;
    end
  end

  // output register
  logic [2:0][InW-1:0] out_mid_d, out_mid_q;
  logic [InW-1:0]      out_gap_d, out_gap_q, out_lam1_q, out_lam2_q;
  logic                out_par_q;

  always_comb begin
    if (sq_q[SqrtSteps].par) begin
      out_mid_d = '0;
      out_gap_d = '0;
    end else begin
      out_mid_d = sq_q[SqrtSteps].mid;
      out_gap_d = sq_q[SqrtSteps].big ? '1 : sq_q[SqrtSteps].root;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_mid_q  <= out_mid_d;
      out_gap_q  <= out_gap_d;
      out_lam1_q <= sq_q[SqrtSteps].lam1;
      out_lam2_q <= sq_q[SqrtSteps].lam2;
      out_par_q  <= sq_q[SqrtSteps].par;
    end
  end

  assign out_valid_o  = vld_q[PipeDepth-1];
  assign mid_x_o      = out_mid_q[0];
  assign mid_y_o      = out_mid_q[1];
  assign mid_z_o      = out_mid_q[2];
  assign gap_o        = out_gap_q;
  assign lambda_one_o = out_lam1_q;
  assign lambda_two_o = out_lam2_q;
  assign parallel_o   = out_par_q;

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DivLastStg] && !dv_q[DivSteps].g.par && !dv_q[DivSteps].ovf1
      |-> dv_q[DivSteps].r1 < dv_q[DivSteps].d)
    else $error("divider remainder not below divisor");

  a_par_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parallel_o |-> gap_o == '0 && lambda_one_o == '0 &&
      lambda_two_o == '0 && mid_x_o == '0 && mid_y_o == '0 && mid_z_o == '0)
    else $error("parallel item with nonzero result fields");
`endif

endmodule

`default_nettype wire
